@@ rtl/transport_segment_reassembler_core_defines.svh @@
// Assertion macros for the reassembler core.
`ifndef TRANSPORT_SEGMENT_REASSEMBLER_CORE_DEFINES_SVH
`define TRANSPORT_SEGMENT_REASSEMBLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reassembler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reassembler assertion failed");

`endif

@@ rtl/tsr_pkg.sv @@
package tsr_pkg;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_SEG   = 2'd0,
    OP_EMPTY = 2'd1,
    OP_READ  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOFIR    = 3'd3;
  localparam logic [2:0] ST_BADSEQ   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  // Transport header bit fields.
  localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
  localparam logic [7:0] HDR_FIR_BIT  = 8'h40;
  localparam logic [7:0] HDR_SEQ_MASK = 8'h3F;

  // One input beat.
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        seg_first;
    logic        seg_last;
    logic [10:0] read_addr;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] frag_len;
    logic [7:0]  read_byte;
    logic        dropped_partial;
    logic [31:0] ok_count;
    logic [31:0] err_count;
  } result_t;

endpackage

@@ rtl/tsr_store.sv @@
module tsr_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Byte write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a write to the same address in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

@@ rtl/tsr_ctrl.sv @@
module tsr_ctrl #(
  parameter int BUF_BYTES = 2048,
  parameter int AW        = 11,
  parameter int LW        = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  tsr_pkg::item_t    item,
  input  logic [7:0]        rdata,
  output logic              res_valid,
  output tsr_pkg::result_t  res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [7:0]        mem_wdata
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COLLECT,
    MODE_DISCARD
  } mode_t;

  // Reassembly state.
  logic [LW-1:0] held_len, held_len_next;
  logic [LW-1:0] write_ptr, write_ptr_next;
  logic [5:0]    expected_seq, expected_seq_next;
  mode_t         seg_mode, seg_mode_next;
  logic          seg_fin, seg_fin_next;
  logic          seg_dropped, seg_dropped_next;
  logic [LW-1:0] done_len, done_len_next;
  logic [31:0]   good_total, good_total_next;
  logic [31:0]   bad_total, bad_total_next;

  logic          we;
  logic          start_seg;
  logic          finish_seg;
  logic          reject;
  logic [2:0]    rej_status;
  logic          rej_drop;
  logic [5:0]    hdr_seq;
  logic          read_in_range;
  logic [LW+11:0] flen_wide;

  assign hdr_seq = 6'(item.data & tsr_pkg::HDR_SEQ_MASK);
  assign read_in_range = ({{LW{1'b0}}, item.read_addr} < {11'b0, done_len});

  // Next state and result for the beat held in the input register.
  always_comb begin
    held_len_next     = held_len;
    write_ptr_next    = write_ptr;
    expected_seq_next = expected_seq;
    seg_mode_next     = seg_mode;
    seg_fin_next      = seg_fin;
    seg_dropped_next  = seg_dropped;
    done_len_next     = done_len;
    good_total_next   = good_total;
    bad_total_next    = bad_total;
    res_valid         = 1'b0;
    res               = '0;
    we                = 1'b0;
    start_seg         = 1'b0;
    finish_seg        = 1'b0;
    reject            = 1'b0;
    rej_status        = tsr_pkg::ST_ACCEPT;
    rej_drop          = 1'b0;
    flen_wide         = '0;

    unique case (item.op)
      tsr_pkg::OP_EMPTY: begin
        seg_mode_next  = MODE_IDLE;
        bad_total_next = bad_total + 32'd1;
        res_valid      = 1'b1;
        res.status     = tsr_pkg::ST_EMPTY;
      end
      tsr_pkg::OP_READ: begin
        res_valid     = 1'b1;
        res.status    = tsr_pkg::ST_READ;
        res.read_byte = read_in_range ? rdata : 8'd0;
      end
      tsr_pkg::OP_RESET: begin
        expected_seq_next = '0;
        held_len_next     = '0;
        write_ptr_next    = '0;
        seg_mode_next     = MODE_IDLE;
        seg_fin_next      = 1'b0;
        seg_dropped_next  = 1'b0;
      end
      tsr_pkg::OP_SEG: begin
        if (item.seg_first) begin
          // Header byte: FIR restarts, otherwise the sequence must continue.
          seg_fin_next     = ((item.data & tsr_pkg::HDR_FIN_BIT) != 8'd0);
          seg_dropped_next = 1'b0;
          if ((item.data & tsr_pkg::HDR_FIR_BIT) != 8'd0) begin
            expected_seq_next = hdr_seq;
            if (held_len != '0) begin
              held_len_next    = '0;
              seg_dropped_next = 1'b1;
            end
            start_seg = 1'b1;
          end else if (held_len == '0) begin
            reject     = 1'b1;
            rej_status = tsr_pkg::ST_NOFIR;
          end else if (hdr_seq != expected_seq) begin
            reject     = 1'b1;
            rej_status = tsr_pkg::ST_BADSEQ;
          end else begin
            start_seg = 1'b1;
          end
          if (start_seg) begin
            write_ptr_next = held_len_next;
            seg_mode_next  = MODE_COLLECT;
            finish_seg     = item.seg_last;
          end
        end else if (seg_mode == MODE_COLLECT) begin
          // Payload byte: store it unless the buffer is full.
          if (write_ptr >= LW'(BUF_BYTES)) begin
            held_len_next = '0;
            reject        = 1'b1;
            rej_status    = tsr_pkg::ST_OVERFLOW;
            rej_drop      = seg_dropped;
          end else begin
            we             = 1'b1;
            write_ptr_next = write_ptr + LW'(1);
            finish_seg     = item.seg_last;
          end
        end else if ((seg_mode == MODE_DISCARD) && item.seg_last) begin
          seg_mode_next = MODE_IDLE;
        end
      end
    endcase

    // Rejected segment: count it and skip the rest of it.
    if (reject) begin
      bad_total_next      = bad_total + 32'd1;
      seg_mode_next       = item.seg_last ? MODE_IDLE : MODE_DISCARD;
      res_valid           = 1'b1;
      res.status          = rej_status;
      res.dropped_partial = rej_drop;
    end

    // Segment ended normally: commit it and report it, as complete on FIN with data.
    if (finish_seg) begin
      good_total_next     = good_total + 32'd1;
      held_len_next       = write_ptr_next;
      expected_seq_next   = expected_seq_next + 6'd1;
      seg_mode_next       = MODE_IDLE;
      res_valid           = 1'b1;
      res.dropped_partial = seg_dropped_next;
      if (seg_fin_next && (write_ptr_next != '0)) begin
        done_len_next = write_ptr_next;
        held_len_next = '0;
        flen_wide     = {12'b0, write_ptr_next};
        res.status    = tsr_pkg::ST_COMPLETE;
        res.frag_len  = flen_wide[11:0];
      end else begin
        if (seg_fin_next) begin
          held_len_next = '0;
        end
        res.status = tsr_pkg::ST_ACCEPT;
      end
    end

    res.ok_count  = good_total_next;
    res.err_count = bad_total_next;
  end

  assign mem_we    = we && adv;
  assign mem_waddr = write_ptr[AW-1:0];
  assign mem_wdata = item.data;

  // State registers advance once per processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_len     <= '0;
      write_ptr    <= '0;
      expected_seq <= '0;
      seg_mode     <= MODE_IDLE;
      seg_fin      <= 1'b0;
      seg_dropped  <= 1'b0;
      done_len     <= '0;
      good_total   <= '0;
      bad_total    <= '0;
    end else if (adv) begin
      held_len     <= held_len_next;
      write_ptr    <= write_ptr_next;
      expected_seq <= expected_seq_next;
      seg_mode     <= seg_mode_next;
      seg_fin      <= seg_fin_next;
      seg_dropped  <= seg_dropped_next;
      done_len     <= done_len_next;
      good_total   <= good_total_next;
      bad_total    <= bad_total_next;
    end
  end

endmodule

@@ rtl/transport_segment_reassembler_core.sv @@
// A beat that gives a result passes the input register, then the result
// register, and holds there while out_stall is high. Throughput: one beat
// per cycle unless out_stall stalls results; the input register, one pass of
// control logic with a single fragment-store write port, result register.
// Reset (rst, synchronous): sequence, held length, counters and handshake
// state clear at once; fragment store contents stay undefined until written.
`include "transport_segment_reassembler_core_defines.svh"

module transport_segment_reassembler_core #(
  parameter int BUF_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  data,
  input  logic        seg_first,
  input  logic        seg_last,
  input  logic [10:0] read_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [11:0] frag_len,
  output logic [7:0]  read_byte,
  output logic        dropped_partial,
  output logic [31:0] ok_count,
  output logic [31:0] err_count
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int LW = $clog2(BUF_BYTES + 1);

  logic             s1_valid;
  tsr_pkg::item_t   s1_item;
  logic             s1_adv;
  logic             in_accept;
  logic             out_free;
  logic             res_valid;
  tsr_pkg::result_t res;
  tsr_pkg::result_t out_res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  logic [AW+10:0]   raddr_wide;

  // Handshake: the held beat moves on when it has no result or room waits.
  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && (!res_valid || out_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.op        <= tsr_pkg::op_t'(op);
      s1_item.data      <= data;
      s1_item.seg_first <= seg_first;
      s1_item.seg_last  <= seg_last;
      s1_item.read_addr <= read_addr;
    end
  end

  // Fragment store, read alongside the input register.
  assign raddr_wide = {{AW{1'b0}}, read_addr};

  tsr_store #(
    .DEPTH (BUF_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (raddr_wide[AW-1:0]),
    .rdata (mem_rdata)
  );

  tsr_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW),
    .LW        (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_adv),
    .item      (s1_item),
    .rdata     (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign status          = out_res.status;
  assign frag_len        = out_res.frag_len;
  assign read_byte       = out_res.read_byte;
  assign dropped_partial = out_res.dropped_partial;
  assign ok_count        = out_res.ok_count;
  assign err_count       = out_res.err_count;

  // Checks on the result register and the input hold path.
  `TSR_ASSERT_NOW(a_stall_needs_held, clk, rst, in_stall, s1_valid)
  `TSR_ASSERT_NOW(a_len_only_on_complete, clk, rst,
    out_valid && (status != tsr_pkg::ST_COMPLETE), frag_len == 12'd0)
  `TSR_ASSERT_NOW(a_byte_only_on_read, clk, rst,
    out_valid && (status != tsr_pkg::ST_READ), read_byte == 8'd0)
  `TSR_ASSERT_NOW(a_no_drop_on_header_reject, clk, rst,
    out_valid && ((status == tsr_pkg::ST_NOFIR) || (status == tsr_pkg::ST_BADSEQ)
      || (status == tsr_pkg::ST_EMPTY)), dropped_partial == 1'b0)

endmodule
